@@ rtl/ilb_pkg.sv @@
// package of shared widths, codes and types for the iso lut blend block
package ilb_pkg;

   localparam int KIND_W     = 2;
   localparam int TAB_W      = 4;
   localparam int PT_W       = 10;
   localparam int KEY_W      = 32;
   localparam int CH_W       = 16;
   localparam int CH_N       = 4;
   localparam int ENTRY_W    = CH_W * CH_N;
   localparam int WGT_W      = 16;
   localparam int TIDX_W     = 6;
   localparam int TC_W       = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [KIND_W-1:0] KIND_KEY   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_GAIN = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_COUNT = 1'b1;

   typedef struct packed {
      logic [KEY_W-1:0]  min_k;
      logic [KEY_W-1:0]  max_k;
      logic [KEY_W-1:0]  lo_k;
      logic [KEY_W-1:0]  hi_k;
      logic [TIDX_W-1:0] min_t;
      logic [TIDX_W-1:0] max_t;
      logic [TIDX_W-1:0] lo_t;
      logic [TIDX_W-1:0] hi_t;
   } ilb_scan_type;

endpackage

@@ rtl/ilb_if.sv @@
// request and response channel interfaces
interface ilb_req_if import ilb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [TAB_W-1:0]  table_index;
   logic [PT_W-1:0]   point_index;
   logic [KEY_W-1:0]  iso_key;
   logic [CH_W-1:0]   red_value;
   logic [CH_W-1:0]   green_red_value;
   logic [CH_W-1:0]   green_blue_value;
   logic [CH_W-1:0]   blue_value;

   modport source (
      output valid, kind, table_index, point_index, iso_key,
             red_value, green_red_value, green_blue_value, blue_value,
      input  ready
   );
   modport sink (
      input  valid, kind, table_index, point_index, iso_key,
             red_value, green_red_value, green_blue_value, blue_value,
      output ready
   );
endinterface

interface ilb_rsp_if import ilb_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [PT_W-1:0] out_point;
   logic [CH_W-1:0] out_red;
   logic [CH_W-1:0] out_green_red;
   logic [CH_W-1:0] out_green_blue;
   logic [CH_W-1:0] out_blue;

   modport source (
      output valid, out_point, out_red, out_green_red, out_green_blue, out_blue,
      input  ready
   );
   modport sink (
      input  valid, out_point, out_red, out_green_red, out_green_blue, out_blue,
      output ready
   );
endinterface

@@ rtl/ilb_key_scan.sv @@
// iso key memory and serial bracket scan over the active tables
module ilb_key_scan import ilb_pkg::*; #(
   parameter int TABLES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              key_we,
   input  logic [((TABLES > 1) ? $clog2(TABLES) : 1)-1:0] key_waddr,
   input  logic [KEY_W-1:0]                  key_wdata,
   input  logic                              start,
   input  logic [$clog2(TABLES + 1)-1:0]     count,
   input  logic [KEY_W-1:0]                  cur_iso,
   output logic                              done,
   output ilb_scan_type                      scan
);

   localparam int TW = (TABLES > 1) ? $clog2(TABLES) : 1;
   localparam int CW = $clog2(TABLES + 1);

   logic [KEY_W-1:0]  keys_mem [TABLES];
   logic [KEY_W-1:0]  key_rd_ff;
   logic [CW-1:0]     issue_ff, issue_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              run_ff, run_in;
   logic              vld_ff, last_ff, done_ff;
   logic [TIDX_W-1:0] idx_ff;
   logic              lo_ok_ff, lo_ok_in, hi_ok_ff, hi_ok_in;
   ilb_scan_type      acc_ff, acc_in;
   logic              first, le_cur;

   always_ff @(posedge clock) begin
      if (key_we) begin
         keys_mem[key_waddr] <= key_wdata;
      end
      if (run_ff) begin
         key_rd_ff <= keys_mem[issue_ff[TW-1:0]];
      end
   end

   always_comb begin
      issue_in = issue_ff;
      count_in = count_ff;
      run_in   = run_ff;
      if (start) begin
         issue_in = '0;
         count_in = count;
         run_in   = 1'b1;
      end else if (run_ff) begin
         issue_in = issue_ff + CW'(1);
         if (issue_ff == count_ff - CW'(1)) begin
            run_in = 1'b0;
         end
      end
   end

   assign first  = (idx_ff == '0);
   assign le_cur = (key_rd_ff <= cur_iso);

   always_comb begin
      acc_in   = acc_ff;
      lo_ok_in = lo_ok_ff;
      hi_ok_in = hi_ok_ff;
      if (vld_ff) begin
         if (first || key_rd_ff < acc_ff.min_k) begin
            acc_in.min_k = key_rd_ff;
            acc_in.min_t = idx_ff;
         end
         if (first || key_rd_ff >= acc_ff.max_k) begin
            acc_in.max_k = key_rd_ff;
            acc_in.max_t = idx_ff;
         end
         lo_ok_in = first ? le_cur : (lo_ok_ff | le_cur);
         hi_ok_in = first ? !le_cur : (hi_ok_ff | !le_cur);
         if (le_cur) begin
            if (first || !lo_ok_ff || key_rd_ff >= acc_ff.lo_k) begin
               acc_in.lo_k = key_rd_ff;
               acc_in.lo_t = idx_ff;
            end
         end else begin
            if (first || !hi_ok_ff || key_rd_ff < acc_ff.hi_k) begin
               acc_in.hi_k = key_rd_ff;
               acc_in.hi_t = idx_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         vld_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         vld_ff  <= run_ff;
         done_ff <= vld_ff && last_ff;
      end
      issue_ff <= issue_in;
      count_ff <= count_in;
      idx_ff   <= TIDX_W'(issue_ff);
      last_ff  <= (issue_ff == count_ff - CW'(1));
      acc_ff   <= acc_in;
      lo_ok_ff <= lo_ok_in;
      hi_ok_ff <= hi_ok_in;
   end

   assign done = done_ff;
   assign scan = acc_ff;

endmodule

@@ rtl/ilb_divider.sv @@
// restoring divider for the q16 blend weight, one quotient bit per cycle
module ilb_divider import ilb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [KEY_W-1:0] num,
   input  logic [KEY_W-1:0] den,
   output logic             done,
   output logic [WGT_W-1:0] quo
);

   localparam int NW = $clog2(WGT_W + 1);

   logic [KEY_W-1:0] rem_ff, rem_in;
   logic [KEY_W-1:0] den_ff;
   logic [WGT_W-1:0] quo_ff, quo_in;
   logic [NW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff;
   logic [KEY_W:0]   shifted;
   logic [KEY_W+1:0] diff;
   logic             ge;
   logic             last_step;

   assign shifted   = {rem_ff, 1'b0};
   assign diff      = {1'b0, shifted} - {2'b00, den_ff};
   assign ge        = !diff[KEY_W+1];
   assign last_step = (cnt_ff == NW'(WGT_W - 1));

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = num;
         quo_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[KEY_W-1:0] : shifted[KEY_W-1:0];
         quo_in = {quo_ff[WGT_W-2:0], ge};
         cnt_in = cnt_ff + NW'(1);
         if (last_step) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= busy_ff && last_step;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (start) begin
         den_ff <= den;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

@@ rtl/ilb_lut_blend.sv @@
// calibration entry memory and channel-serial linear blend
module ilb_lut_blend import ilb_pkg::*; #(
   parameter int TABLES      = 16,
   parameter int GRID_POINTS = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [((TABLES * GRID_POINTS > 1) ? $clog2(TABLES * GRID_POINTS) : 1)-1:0] wr_addr,
   input  logic [ENTRY_W-1:0]   wr_data,
   input  logic                 start,
   input  logic [((TABLES * GRID_POINTS > 1) ? $clog2(TABLES * GRID_POINTS) : 1)-1:0] lo_addr,
   input  logic [((TABLES * GRID_POINTS > 1) ? $clog2(TABLES * GRID_POINTS) : 1)-1:0] hi_addr,
   input  logic [WGT_W-1:0]     weight,
   output logic                 done,
   output logic [ENTRY_W-1:0]   result
);

   localparam int DEPTH = TABLES * GRID_POINTS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CHX   = $clog2(CH_N);

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_HI   = 2'd1;
   localparam logic [1:0] B_CH   = 2'd2;

   logic [ENTRY_W-1:0]        lut_mem [DEPTH];
   logic [ENTRY_W-1:0]        rd_ff;
   logic [ENTRY_W-1:0]        e0_ff;
   logic [AW-1:0]             hi_addr_ff;
   logic [WGT_W-1:0]          w_ff;
   logic [1:0]                phase_ff, phase_in;
   logic [CHX-1:0]            ch_ff, ch_in;
   logic                      done_ff, done_in;
   logic [CH_N-1:0][CH_W-1:0] res_ff;
   logic                      rd_en;
   logic [AW-1:0]             rd_addr;
   logic [CH_W-1:0]           v0, v1;
   logic signed [CH_W:0]      delta;
   logic signed [2*CH_W+1:0]  prod;
   logic [CH_W-1:0]           ch_res;

   assign rd_en   = start || (phase_ff == B_HI);
   assign rd_addr = start ? lo_addr : hi_addr_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         lut_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= lut_mem[rd_addr];
      end
   end

   assign v0     = e0_ff[{ch_ff, 4'b0000} +: CH_W];
   assign v1     = rd_ff[{ch_ff, 4'b0000} +: CH_W];
   assign delta  = $signed({1'b0, v1}) - $signed({1'b0, v0});
   assign prod   = delta * $signed({1'b0, w_ff});
   assign ch_res = v0 + prod[2*CH_W-1:CH_W];

   always_comb begin
      phase_in = phase_ff;
      ch_in    = ch_ff;
      done_in  = 1'b0;
      unique case (phase_ff)
         B_IDLE: begin
            if (start) begin
               phase_in = B_HI;
            end
         end
         B_HI: begin
            phase_in = B_CH;
            ch_in    = '0;
         end
         B_CH: begin
            ch_in = ch_ff + CHX'(1);
            if (ch_ff == CHX'(CH_N - 1)) begin
               phase_in = B_IDLE;
               done_in  = 1'b1;
            end
         end
         default: begin
            phase_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= B_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      ch_ff <= ch_in;
      if (start) begin
         hi_addr_ff <= hi_addr;
         w_ff       <= weight;
      end
      if (phase_ff == B_HI) begin
         e0_ff <= rd_ff;
      end
      if (phase_ff == B_CH) begin
         res_ff[ch_ff] <= ch_res;
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

@@ rtl/iso_lut_blend.sv @@
// Top level of the ISO-indexed calibration table blend. Key writes and entry
// writes leave the block in its idle state, so it is ready again on the next
// cycle. A read of a grid point scans the key memory one key per cycle over
// the effective table count. When the sensor gain clamps to the lowest or
// highest table the read uses that table alone; when two tables are blended,
// the blend weight comes from a 16-step serial divider. The two entries come
// one after the other from the single read port of the entry memory before
// the four channels are blended one per cycle. A read beyond the grid skips
// the scan and answers with a zero word. A finished result waits in the
// output register while the next word is taken in.
module iso_lut_blend import ilb_pkg::*; #(
   parameter int TABLES      = 16,
   parameter int GRID_POINTS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   ilb_req_if.sink               req_if,
   ilb_rsp_if.source             rsp_if,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int TW    = (TABLES > 1) ? $clog2(TABLES) : 1;
   localparam int CW    = $clog2(TABLES + 1);
   localparam int DEPTH = TABLES * GRID_POINTS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DIV    = 3'd2;
   localparam logic [2:0] S_LAUNCH = 3'd3;
   localparam logic [2:0] S_BLEND  = 3'd4;
   localparam logic [2:0] S_HOLD   = 3'd5;

   logic [KEY_W-1:0]   iso_gain_ff;
   logic [TC_W-1:0]    table_count_ff;
   logic [2:0]         state_ff, state_in;
   logic [PT_W-1:0]    pt_ff;
   logic               zero_ff;
   logic               one_ff;
   logic [TIDX_W-1:0]  lo_t_ff, lo_t_in, hi_t_ff, hi_t_in;
   logic [WGT_W-1:0]   w_ff, w_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PT_W-1:0]    out_point_ff;
   logic [ENTRY_W-1:0] out_data_ff;

   logic [CW-1:0]      n_eff;
   logic               accept, tab_ok, pt_ok;
   logic               key_we, lut_we;
   logic               read_go;
   logic               scan_done;
   ilb_scan_type       scan;
   logic               div_start, div_done;
   logic [WGT_W-1:0]   div_quo;
   logic               blend_start, blend_done;
   logic [ENTRY_W-1:0] blend_res;
   logic               load;
   logic               clamp_lo, clamp_hi;

   function automatic logic [AW-1:0] lut_addr(input logic [TIDX_W-1:0] t,
                                              input logic [PT_W-1:0] p);
      lut_addr = AW'(32'(t) * 32'(GRID_POINTS) + 32'(p));
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         iso_gain_ff    <= '0;
         table_count_ff <= TC_W'(1);
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SENSOR_GAIN: iso_gain_ff    <= csr_wdata;
            CSR_TABLE_COUNT: table_count_ff <= csr_wdata[TC_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (table_count_ff == '0) begin
         n_eff = CW'(1);
      end else if (32'(table_count_ff) > 32'(TABLES)) begin
         n_eff = CW'(TABLES);
      end else begin
         n_eff = CW'(table_count_ff);
      end
   end

   assign req_if.ready = (state_ff == S_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign tab_ok       = 32'(req_if.table_index) < 32'(TABLES);
   assign pt_ok        = 32'(req_if.point_index) < 32'(GRID_POINTS);
   assign key_we       = accept && (req_if.kind == KIND_KEY) && tab_ok;
   assign lut_we       = accept && (req_if.kind == KIND_ENTRY) && tab_ok && pt_ok;
   assign read_go      = accept && (req_if.kind == KIND_READ);

   assign clamp_lo = one_ff || (iso_gain_ff <= scan.min_k);
   assign clamp_hi = (iso_gain_ff >= scan.max_k);

   assign div_start   = (state_ff == S_SCAN) && scan_done && !clamp_lo && !clamp_hi;
   assign blend_start = (state_ff == S_LAUNCH);
   assign load        = (state_ff == S_HOLD) && (!rsp_valid_ff || rsp_if.ready);

   always_comb begin
      state_in = state_ff;
      lo_t_in  = lo_t_ff;
      hi_t_in  = hi_t_ff;
      w_in     = w_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (read_go) begin
               state_in = pt_ok ? S_SCAN : S_HOLD;
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               if (clamp_lo) begin
                  lo_t_in  = scan.min_t;
                  hi_t_in  = scan.min_t;
                  w_in     = '0;
                  state_in = S_LAUNCH;
               end else if (clamp_hi) begin
                  lo_t_in  = scan.max_t;
                  hi_t_in  = scan.max_t;
                  w_in     = '0;
                  state_in = S_LAUNCH;
               end else begin
                  lo_t_in  = scan.lo_t;
                  hi_t_in  = scan.hi_t;
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               w_in     = div_quo;
               state_in = S_LAUNCH;
            end
         end
         S_LAUNCH: begin
            state_in = S_BLEND;
         end
         S_BLEND: begin
            if (blend_done) begin
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load ? 1'b1 : ((rsp_valid_ff && rsp_if.ready) ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_t_ff <= lo_t_in;
      hi_t_ff <= hi_t_in;
      w_ff    <= w_in;
      if (read_go) begin
         pt_ff   <= req_if.point_index;
         zero_ff <= !pt_ok;
         one_ff  <= (n_eff == CW'(1));
      end
      if (load) begin
         out_point_ff <= pt_ff;
         out_data_ff  <= zero_ff ? '0 : blend_res;
      end
   end

   ilb_key_scan #(
      .TABLES (TABLES)
   ) u_key_scan (
      .clock     (clock),
      .reset     (reset),
      .key_we    (key_we),
      .key_waddr (TW'(req_if.table_index)),
      .key_wdata (req_if.iso_key),
      .start     (read_go && pt_ok),
      .count     (n_eff),
      .cur_iso   (iso_gain_ff),
      .done      (scan_done),
      .scan      (scan)
   );

   ilb_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (iso_gain_ff - scan.lo_k),
      .den   (scan.hi_k - scan.lo_k),
      .done  (div_done),
      .quo   (div_quo)
   );

   ilb_lut_blend #(
      .TABLES      (TABLES),
      .GRID_POINTS (GRID_POINTS)
   ) u_lut_blend (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (lut_we),
      .wr_addr (lut_addr(TIDX_W'(req_if.table_index), req_if.point_index)),
      .wr_data ({req_if.blue_value, req_if.green_blue_value,
                 req_if.green_red_value, req_if.red_value}),
      .start   (blend_start),
      .lo_addr (lut_addr(lo_t_ff, pt_ff)),
      .hi_addr (lut_addr(hi_t_ff, pt_ff)),
      .weight  (w_ff),
      .done    (blend_done),
      .result  (blend_res)
   );

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.out_point      = out_point_ff;
   assign rsp_if.out_red        = out_data_ff[CH_W-1:0];
   assign rsp_if.out_green_red  = out_data_ff[2*CH_W-1:CH_W];
   assign rsp_if.out_green_blue = out_data_ff[3*CH_W-1:2*CH_W];
   assign rsp_if.out_blue       = out_data_ff[4*CH_W-1:3*CH_W];

   a_scan_done_in_scan: assert property (@(posedge clock) disable iff (reset)
      scan_done |-> (state_ff == S_SCAN))
      else $error("key scan finished outside the scan state");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide state");

   a_blend_done_in_blend: assert property (@(posedge clock) disable iff (reset)
      blend_done |-> (state_ff == S_BLEND))
      else $error("blend finished outside the blend state");

   a_load_shows_word: assert property (@(posedge clock) disable iff (reset)
      load |=> (rsp_valid_ff && (state_ff == S_IDLE)))
      else $error("loaded result word not presented");

endmodule
